// File: hdl/addressed_frame_receiver_macros.svh
// Assertion macros shared by the frame receiver.
`ifndef ADDRESSED_FRAME_RECEIVER_MACROS_SVH
`define ADDRESSED_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define AFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/afr_pkg.sv
`timescale 1ns / 1ps
package afr_pkg;

  // Frame store geometry and command limit.
  localparam int BUFFER_SIZE = 64;
  localparam int MAX_COMMAND = 64;
  localparam int FILL_W = $clog2(BUFFER_SIZE);
  localparam int LEN_W = 6;
  localparam int CMP_W = 10;

  // Framing bytes.
  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] END_BYTE = 8'h55;
  localparam logic [7:0] BCAST_ID = 8'hFF;
  localparam int MIN_FRAME = 4;
  localparam int HDR_BYTES = 3;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DATA,
    S_HDR
  } afr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic start_drain;
    logic rd;
    logic advance;
    logic show_data;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic close;
    logic addressed;
    logic payload_ok;
    logic last_item;
  } dp_status_t;

endpackage

// File: hdl/addressed_frame_receiver.sv
// Input bytes are taken only in the idle state; no request is accepted while a frame's results drain.
// A closing byte for this address moves to a store read state, then to a present state that
// offers a payload result; each further result repeats read, then present, and stalls hold present.
// A header-only result appears in the cycle after the closing byte.
// Synchronous active-high reset clears the fill count, state and address to zero.
`timescale 1ns / 1ps
`include "addressed_frame_receiver_macros.svh"
module addressed_frame_receiver import afr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] target_id,
  output logic       is_broadcast,
  output logic [7:0] command_type,
  output logic [5:0] payload_length,
  output logic       payload_valid,
  output logic [7:0] payload_byte,
  output logic       last
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer for byte intake and payload drain.
  afr_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Frame store, header registers and result fields.
  afr_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .rx_byte       (rx_byte),
    .cmd           (cmd),
    .status        (status),
    .target_id     (target_id),
    .is_broadcast  (is_broadcast),
    .command_type  (command_type),
    .payload_length(payload_length),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .last          (last)
  );

  // Intake is held off for as long as a result is on offer.
  `AFR_ASSERT_NOW(a_stall_while_out, clk, rst, out_valid, in_stall, "input taken during drain")
  // A header-only result is always the last one and carries a zero byte.
  `AFR_ASSERT_NOW(a_hdr_last, clk, rst, out_valid && !payload_valid, last && (payload_byte == 8'h00), "bad header-only result")
  // The last result of a run ends the drain.
  `AFR_ASSERT_NEXT(a_run_end, clk, rst, out_valid && last && !out_stall, !out_valid, "result after last")

endmodule

// File: hdl/afr_ram.sv
`timescale 1ns / 1ps
module afr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/afr_datapath.sv
`timescale 1ns / 1ps
module afr_datapath import afr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_data,
  input  logic [7:0]   rx_byte,
  input  ctrl_cmd_t    cmd,
  output dp_status_t   status,
  output logic [7:0]   target_id,
  output logic         is_broadcast,
  output logic [7:0]   command_type,
  output logic [5:0]   payload_length,
  output logic         payload_valid,
  output logic [7:0]   payload_byte,
  output logic         last
);

  logic [7:0]        device_address;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [7:0]        frame_id;
  logic [7:0]        frame_cmd;
  logic [FILL_W-1:0] len;
  logic [FILL_W-1:0] idx;
  logic [7:0]        rdata;
  logic              is_start;
  logic              in_range;
  logic              store_we;
  logic [FILL_W-1:0] store_waddr;
  logic [FILL_W-1:0] store_raddr;

  // Byte classification against the current fill.
  assign is_start = (rx_byte == START_BYTE);
  assign in_range = (fill != '0) && (fill < FILL_W'(BUFFER_SIZE - 1));

  // Close and payload checks use the fill before this byte is counted.
  assign status.close = !is_start && in_range && (rx_byte == END_BYTE) &&
                        (fill >= FILL_W'(MIN_FRAME - 1));
  assign status.addressed = (frame_id == device_address) || (frame_id == BCAST_ID);
  assign status.payload_ok = (fill > FILL_W'(MIN_FRAME - 1)) &&
                             (CMP_W'(fill) <= CMP_W'(MAX_COMMAND));
  assign status.last_item = (idx == (len - FILL_W'(1)));

  // Next fill count.
  always_comb begin
    if (is_start) begin
      fill_next = FILL_W'(1);
    end else if (in_range && !status.close) begin
      fill_next = fill + FILL_W'(1);
    end else begin
      fill_next = '0;
    end
  end

  // Control registers: configured address and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'h00;
      fill <= '0;
    end else begin
      if (cfg_we) begin
        device_address <= cfg_data;
      end
      if (cmd.take) begin
        fill <= fill_next;
      end
    end
  end

  // Header capture, payload length and drain index.
  always_ff @(posedge clk) begin
    if (cmd.take && !is_start && in_range) begin
      if (fill == FILL_W'(1)) begin
        frame_id <= rx_byte;
      end
      if (fill == FILL_W'(2)) begin
        frame_cmd <= rx_byte;
      end
    end
    if (cmd.start_drain) begin
      len <= fill - FILL_W'(MIN_FRAME - 1);
      idx <= '0;
    end else if (cmd.advance) begin
      idx <= idx + FILL_W'(1);
    end
  end

  // Frame store write and payload read addresses.
  assign store_we = cmd.take && (is_start || in_range);
  assign store_waddr = is_start ? '0 : fill;
  assign store_raddr = FILL_W'(HDR_BYTES) + idx;

  afr_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_SIZE)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(store_waddr),
    .wdata(rx_byte),
    .re   (cmd.rd),
    .raddr(store_raddr),
    .rdata(rdata)
  );

  // Result fields.
  assign target_id = frame_id;
  assign is_broadcast = (frame_id == BCAST_ID);
  assign command_type = frame_cmd;
  assign payload_length = len[LEN_W-1:0];
  assign payload_valid = cmd.show_data;
  assign payload_byte = cmd.show_data ? rdata : 8'h00;
  assign last = cmd.show_data ? status.last_item : 1'b1;

endmodule

// File: hdl/afr_controller.sv
`timescale 1ns / 1ps
module afr_controller import afr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  afr_state_t state;
  afr_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
        if (in_valid && status.close && status.addressed) begin
          cmd.start_drain = 1'b1;
          state_next = status.payload_ok ? S_READ : S_HDR;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_next = S_DATA;
      end
      S_DATA: begin
        out_valid = 1'b1;
        cmd.show_data = 1'b1;
        if (!out_stall) begin
          if (status.last_item) begin
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_HDR: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

endmodule
